// ----- design/grr_pkg.sv -----
package grr_pkg;

  // Widths fixed by the register and field definitions.
  localparam int DIM_W   = 7;
  localparam int IDX_W   = 6;
  localparam int SHIFT_W = 31;
  // A ring is at most 2*(126+126) cells long.
  localparam int LEN_W   = 9;
  localparam int CNT_W   = $clog2(SHIFT_W);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_SHIFT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MOD,
    ST_MAP,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] bottom;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
  } ring_geom_t;

  // Handshake with the remainder unit.
  typedef struct packed {
    logic               start;
    logic [SHIFT_W-1:0] dividend;
    logic [LEN_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] remainder;
  } rem_rsp_t;

endpackage

// ----- design/grr_rem_unit.sv -----
module grr_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  grr_pkg::rem_req_t  req,
  output grr_pkg::rem_rsp_t  rsp
);

  logic                        running;
  logic [grr_pkg::CNT_W-1:0]   cnt;
  logic [grr_pkg::SHIFT_W-1:0] dvd;
  logic [grr_pkg::LEN_W-1:0]   divisor;
  logic [grr_pkg::LEN_W-1:0]   rem;
  logic                        done;
  logic [grr_pkg::LEN_W:0]     trial;

  // Restoring division, one dividend bit per cycle. The partial remainder
  // stays below the divisor, so the shifted value needs one extra bit.
  assign trial = {rem, dvd[grr_pkg::SHIFT_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
      cnt     <= grr_pkg::CNT_W'(grr_pkg::SHIFT_W - 1);
    end else if (running) begin
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem <= grr_pkg::LEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[grr_pkg::LEN_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- design/grr_cell_store.sv -----
module grr_cell_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/grid_ring_rotation.sv -----
// Rotates the concentric rings of a grid held in a single-port-write,
// registered-read cell memory. A write word leaves busy low, so writes may
// follow each other every cycle while no read is in progress. A read word
// holds busy high until its result strobe. A cell on a ring passes through
// the ring geometry, the bit-serial remainder unit that reduces the shift
// modulo the ring length (dividend bits, then its done flag), the map back
// to a source cell, the memory read and the output register; a cell on no
// ring goes from the geometry to a read of itself and the output register,
// and an out-of-range read from the geometry to the output register. The
// result sits on the output ports for exactly one cycle with done high;
// there is no way to stall it.
module grid_ring_rotation #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cmd,
  input  logic [grr_pkg::IDX_W-1:0]  row_index,
  input  logic [grr_pkg::IDX_W-1:0]  col_index,
  input  logic signed [31:0]         cell_value,
  output logic                       done,
  output logic signed [31:0]         rotated_value,
  output logic                       out_of_range,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DW     = grr_pkg::DIM_W;
  localparam int LW     = grr_pkg::LEN_W;

  // Configuration registers.
  logic [DW-1:0]               grid_rows;
  logic [DW-1:0]               grid_cols;
  logic [grr_pkg::SHIFT_W-1:0] shift_amount;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= DW'(64);
      grid_cols    <= DW'(64);
      shift_amount <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        grr_pkg::REG_ROWS:  grid_rows    <= pwdata[DW-1:0];
        grr_pkg::REG_COLS:  grid_cols    <= pwdata[DW-1:0];
        grr_pkg::REG_SHIFT: shift_amount <= pwdata[grr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      grr_pkg::REG_ROWS:  prdata = {{(32-DW){1'b0}}, grid_rows};
      grr_pkg::REG_COLS:  prdata = {{(32-DW){1'b0}}, grid_cols};
      grr_pkg::REG_SHIFT: prdata = {1'b0, shift_amount};
      default:            prdata = '0;
    endcase
  end

  // Dimensions in use: zero counts as one, anything above the maximum as it.
  logic [DW-1:0] rows_eff;
  logic [DW-1:0] cols_eff;

  always_comb begin
    if (grid_rows == '0) rows_eff = DW'(1);
    else if (int'(grid_rows) > MAX_ROWS) rows_eff = DW'(MAX_ROWS);
    else rows_eff = grid_rows;
    if (grid_cols == '0) cols_eff = DW'(1);
    else if (int'(grid_cols) > MAX_COLS) cols_eff = DW'(MAX_COLS);
    else cols_eff = grid_cols;
  end

  // Accept and cell writes.
  logic accept;
  logic in_grid_in;
  logic st_wr_en;
  logic [ADDR_W-1:0] st_wr_addr;
  logic [DATA_BITS-1:0] st_wr_data;

  assign accept     = start && !busy;
  assign in_grid_in = ({1'b0, row_index} < rows_eff) && ({1'b0, col_index} < cols_eff);
  assign st_wr_en   = accept && (cmd == grr_pkg::CMD_WRITE) && in_grid_in;
  assign st_wr_addr = ADDR_W'(int'(row_index) * MAX_COLS + int'(col_index));
  assign st_wr_data = DATA_BITS'($unsigned(cell_value));

  grr_pkg::state_t state, state_next;
  logic [grr_pkg::IDX_W-1:0] row_l;
  logic [grr_pkg::IDX_W-1:0] col_l;

  assign busy = (state != grr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept && cmd == grr_pkg::CMD_READ) begin
      row_l <= row_index;
      col_l <= col_index;
    end
  end

  // Ring geometry of the latched cell.
  logic [DW-1:0] r7, c7, d_bot, d_rt, d_min, g_top, g_bot, g_left, g_right, g_h, g_w;
  logic [LW-1:0] g_len, g_pos;
  logic          inside_l;
  logic          on_ring;

  always_comb begin
    r7      = {1'b0, row_l};
    c7      = {1'b0, col_l};
    inside_l = (r7 < rows_eff) && (c7 < cols_eff);
    d_bot   = rows_eff - DW'(1) - r7;
    d_rt    = cols_eff - DW'(1) - c7;
    d_min   = (r7 < c7) ? r7 : c7;
    if (d_bot < d_min) d_min = d_bot;
    if (d_rt < d_min) d_min = d_rt;
    g_top   = d_min;
    g_left  = d_min;
    g_bot   = rows_eff - DW'(1) - d_min;
    g_right = cols_eff - DW'(1) - d_min;
    on_ring = (g_top < g_bot) && (g_left < g_right);
    g_h     = g_bot - g_top;
    g_w     = g_right - g_left;
    g_len   = (LW'(g_h) + LW'(g_w)) << 1;
    // Position along the ring, walking clockwise from the top-left corner.
    if (r7 == g_top) begin
      g_pos = LW'(c7 - g_left);
    end else if (c7 == g_right) begin
      g_pos = LW'(g_w) + LW'(r7 - g_top);
    end else if (r7 == g_bot) begin
      g_pos = LW'(g_w) + LW'(g_h) + LW'(g_right - c7);
    end else begin
      g_pos = (LW'(g_w) << 1) + LW'(g_h) + LW'(g_bot - r7);
    end
  end

  grr_pkg::ring_geom_t geom;
  grr_pkg::rem_req_t   rem_req;
  grr_pkg::rem_rsp_t   rem_rsp;
  logic [LW-1:0]       q_pos;
  logic [LW:0]         q_sum;

  assign q_sum = {1'b0, geom.pos} + {1'b0, rem_rsp.remainder};

  always_ff @(posedge clk) begin
    if (state == grr_pkg::ST_CALC) begin
      geom.top    <= g_top;
      geom.bottom <= g_bot;
      geom.left   <= g_left;
      geom.right  <= g_right;
      geom.h      <= g_h;
      geom.w      <= g_w;
      geom.len    <= g_len;
      geom.pos    <= g_pos;
    end
    if (state == grr_pkg::ST_MOD && rem_rsp.done) begin
      if (q_sum >= {1'b0, geom.len}) q_pos <= LW'(q_sum - {1'b0, geom.len});
      else q_pos <= q_sum[LW-1:0];
    end
  end

  grr_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  // Map the rotated ring position back to a source cell.
  logic [LW-1:0] w9, h9, sr9, sc9;
  logic [DW-1:0] src_r, src_c;

  always_comb begin
    w9 = LW'(geom.w);
    h9 = LW'(geom.h);
    if (q_pos <= w9) begin
      sr9 = LW'(geom.top);
      sc9 = LW'(geom.left) + q_pos;
    end else if (q_pos <= w9 + h9) begin
      sr9 = LW'(geom.top) + (q_pos - w9);
      sc9 = LW'(geom.right);
    end else if (q_pos <= (w9 << 1) + h9) begin
      sr9 = LW'(geom.bottom);
      sc9 = LW'(geom.right) - (q_pos - w9 - h9);
    end else begin
      sr9 = LW'(geom.bottom) - (q_pos - (w9 << 1) - h9);
      sc9 = LW'(geom.left);
    end
    src_r = DW'(sr9);
    src_c = DW'(sc9);
  end

  logic                 st_rd_en;
  logic [ADDR_W-1:0]    st_rd_addr;
  logic [DATA_BITS-1:0] st_rd_data;

  always_comb begin
    state_next       = state;
    rem_req.start    = 1'b0;
    rem_req.dividend = shift_amount;
    rem_req.divisor  = g_len;
    st_rd_en         = 1'b0;
    st_rd_addr       = ADDR_W'(int'(src_r) * MAX_COLS + int'(src_c));
    unique case (state)
      grr_pkg::ST_IDLE: begin
        if (accept && cmd == grr_pkg::CMD_READ) state_next = grr_pkg::ST_CALC;
      end
      grr_pkg::ST_CALC: begin
        priority if (!inside_l) begin
          state_next = grr_pkg::ST_IDLE;
        end else if (on_ring) begin
          rem_req.start = 1'b1;
          state_next    = grr_pkg::ST_MOD;
        end else begin
          // A cell on no ring reads itself.
          st_rd_en   = 1'b1;
          st_rd_addr = ADDR_W'(int'(r7) * MAX_COLS + int'(c7));
          state_next = grr_pkg::ST_LOAD;
        end
      end
      grr_pkg::ST_MOD: begin
        if (rem_rsp.done) state_next = grr_pkg::ST_MAP;
      end
      grr_pkg::ST_MAP: begin
        st_rd_en   = 1'b1;
        state_next = grr_pkg::ST_LOAD;
      end
      grr_pkg::ST_LOAD: begin
        state_next = grr_pkg::ST_IDLE;
      end
      default: state_next = grr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= grr_pkg::ST_IDLE;
    else state <= state_next;
  end

  grr_cell_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Result register: one word per read, shown for a single cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == grr_pkg::ST_LOAD) || (state == grr_pkg::ST_CALC && !inside_l);
    end
  end

  always_ff @(posedge clk) begin
    if (state == grr_pkg::ST_CALC && !inside_l) begin
      rotated_value <= '0;
      out_of_range  <= 1'b1;
    end else if (state == grr_pkg::ST_LOAD) begin
      rotated_value <= 32'(signed'(st_rd_data));
      out_of_range  <= 1'b0;
    end
  end

`ifndef SYNTH
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == grr_pkg::ST_LOAD || state == grr_pkg::ST_CALC))
    else $error("result strobe without a finishing read");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    st_wr_en |-> !busy)
    else $error("cell write while a read is in progress");

  a_rem_in_mod: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> state == grr_pkg::ST_MOD)
    else $error("remainder finished outside the reduction state");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == grr_pkg::CMD_READ) |=> busy)
    else $error("accepted read did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");
`endif

endmodule
